// File: hdl/aapm_pkg.sv
// shared types and constants for the axis-angle to pose matrix unit
// no dependencies; imported by every module of the block
`default_nettype none

package aapm_pkg;

  // one in Q2.30
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  // quotient bits of the axis divider, also the depth the sin/cos path matches
  localparam int DIV_STEPS = 31;

  typedef struct packed {
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
    logic signed [31:0] rotvec_x;
    logic signed [31:0] rotvec_y;
    logic signed [31:0] rotvec_z;
  } aapm_in_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic signed [31:0] out_tx;
    logic signed [31:0] out_ty;
    logic signed [31:0] out_tz;
  } aapm_out_t;

  // data that rides along with a pose
  typedef struct packed {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic [2:0]         neg;
  } aapm_side_t;

  // vector length and component magnitudes
  typedef struct packed {
    logic [31:0]       theta;
    logic [2:0][31:0]  mag;
    aapm_side_t        side;
  } aapm_root_t;

  // unclamped axis quotients
  typedef struct packed {
    logic [2:0][30:0]  q;
    logic              tiny;
    aapm_side_t        side;
  } aapm_axis_t;

  // quadrant-corrected sine and cosine in Q2.30
  typedef struct packed {
    logic signed [31:0] s;
    logic signed [31:0] c;
  } aapm_sc_t;

endpackage

`default_nettype wire

// File: hdl/aapm_sqrt.sv
// front end: component magnitudes, sum of squares, pipelined integer square root
// depends on aapm_pkg
`default_nettype none

module aapm_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  aapm_pkg::aapm_in_t in_data,
  output logic               out_valid,
  output aapm_pkg::aapm_root_t out_root
);
  import aapm_pkg::*;

  localparam int STEPS = 32;

  logic [2:0][31:0] mag_nxt;
  aapm_side_t       side_nxt;

  logic             vld1_r;
  logic [2:0][63:0] sq_r;
  logic [2:0][31:0] mag1_r;
  aapm_side_t       side1_r;

  logic             vld_r  [0:STEPS];
  logic [63:0]      n_r    [0:STEPS];
  logic [34:0]      rem_r  [0:STEPS];
  logic [31:0]      root_r [0:STEPS];
  logic [2:0][31:0] mag_r  [0:STEPS];
  aapm_side_t       side_r [0:STEPS];

  logic [34:0]      rem_sh [0:STEPS-1];
  logic [34:0]      trial  [0:STEPS-1];
  logic             take   [0:STEPS-1];

  // magnitudes and side data of the incoming pose
  always_comb begin
    mag_nxt[0] = in_data.rotvec_x[31] ? 32'(-in_data.rotvec_x) : 32'(in_data.rotvec_x);
    mag_nxt[1] = in_data.rotvec_y[31] ? 32'(-in_data.rotvec_y) : 32'(in_data.rotvec_y);
    mag_nxt[2] = in_data.rotvec_z[31] ? 32'(-in_data.rotvec_z) : 32'(in_data.rotvec_z);
    side_nxt.tx  = in_data.trans_x;
    side_nxt.ty  = in_data.trans_y;
    side_nxt.tz  = in_data.trans_z;
    side_nxt.neg = {in_data.rotvec_z[31], in_data.rotvec_y[31], in_data.rotvec_x[31]};
  end

  // one root bit per stage, two radicand bits consumed
  always_comb begin
    for (int j = 0; j < STEPS; j++) begin
      rem_sh[j] = {rem_r[j][32:0], n_r[j][63:62]};
      trial[j]  = {1'b0, root_r[j], 2'b01};
      take[j]   = (rem_sh[j] >= trial[j]);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      for (int j = 0; j <= STEPS; j++) vld_r[j] <= 1'b0;
    end else if (en) begin
      vld1_r   <= in_valid;
      vld_r[0] <= vld1_r;
      for (int j = 0; j < STEPS; j++) vld_r[j+1] <= vld_r[j];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq_r[i] <= 64'(mag_nxt[i]) * 64'(mag_nxt[i]);
      mag1_r  <= mag_nxt;
      side1_r <= side_nxt;

      n_r[0]    <= sq_r[0] + sq_r[1] + sq_r[2];
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      mag_r[0]  <= mag1_r;
      side_r[0] <= side1_r;

      for (int j = 0; j < STEPS; j++) begin
        n_r[j+1]    <= {n_r[j][61:0], 2'b00};
        rem_r[j+1]  <= take[j] ? (rem_sh[j] - trial[j]) : rem_sh[j];
        root_r[j+1] <= {root_r[j][30:0], take[j]};
        mag_r[j+1]  <= mag_r[j];
        side_r[j+1] <= side_r[j];
      end
    end
  end

  assign out_valid      = vld_r[STEPS];
  assign out_root.theta = root_r[STEPS];
  assign out_root.mag   = mag_r[STEPS];
  assign out_root.side  = side_r[STEPS];

endmodule

`default_nettype wire

// File: hdl/aapm_div.sv
// axis divider: three restoring lanes, one quotient bit per stage
// depends on aapm_pkg
`default_nettype none

module aapm_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  aapm_pkg::aapm_root_t in_root,
  output logic                 out_valid,
  output aapm_pkg::aapm_axis_t out_axis
);
  import aapm_pkg::*;

  localparam logic [31:0] THETA_MIN = 32'd268;

  // stage sources: input for the first stage, previous register after
  logic [2:0][32:0] src_t     [0:DIV_STEPS-1];
  logic [2:0][30:0] src_q     [0:DIV_STEPS-1];
  logic [31:0]      src_theta [0:DIV_STEPS-1];
  logic             src_tiny  [0:DIV_STEPS-1];
  logic             src_vld   [0:DIV_STEPS-1];
  aapm_side_t       src_side  [0:DIV_STEPS-1];
  logic [2:0]       take      [0:DIV_STEPS-1];

  logic             vld_r   [0:DIV_STEPS-1];
  logic [2:0][31:0] rem_r   [0:DIV_STEPS-1];
  logic [2:0][30:0] q_r     [0:DIV_STEPS-1];
  logic [31:0]      theta_r [0:DIV_STEPS-1];
  logic             tiny_r  [0:DIV_STEPS-1];
  aapm_side_t       side_r  [0:DIV_STEPS-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      src_t[0][i] = {1'b0, in_root.mag[i]};
      src_q[0][i] = '0;
    end
    src_theta[0] = in_root.theta;
    src_tiny[0]  = (in_root.theta <= THETA_MIN);
    src_vld[0]   = in_valid;
    src_side[0]  = in_root.side;
    for (int j = 1; j < DIV_STEPS; j++) begin
      for (int i = 0; i < 3; i++) begin
        src_t[j][i] = {rem_r[j-1][i], 1'b0};
        src_q[j][i] = q_r[j-1][i];
      end
      src_theta[j] = theta_r[j-1];
      src_tiny[j]  = tiny_r[j-1];
      src_vld[j]   = vld_r[j-1];
      src_side[j]  = side_r[j-1];
    end
    for (int j = 0; j < DIV_STEPS; j++) begin
      for (int i = 0; i < 3; i++) take[j][i] = (src_t[j][i] >= {1'b0, src_theta[j]});
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < DIV_STEPS; j++) vld_r[j] <= 1'b0;
    end else if (en) begin
      for (int j = 0; j < DIV_STEPS; j++) vld_r[j] <= src_vld[j];
    end
  end

  // compare, subtract and shift
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < DIV_STEPS; j++) begin
        for (int i = 0; i < 3; i++) begin
          rem_r[j][i] <= take[j][i] ? 32'(src_t[j][i] - {1'b0, src_theta[j]})
                                    : src_t[j][i][31:0];
          q_r[j][i]   <= {src_q[j][i][29:0], take[j][i]};
        end
        theta_r[j] <= src_theta[j];
        tiny_r[j]  <= src_tiny[j];
        side_r[j]  <= src_side[j];
      end
    end
  end

  assign out_valid     = vld_r[DIV_STEPS-1];
  assign out_axis.q    = q_r[DIV_STEPS-1];
  assign out_axis.tiny = tiny_r[DIV_STEPS-1];
  assign out_axis.side = side_r[DIV_STEPS-1];

endmodule

`default_nettype wire

// File: hdl/aapm_sincos.sv
// sine and cosine of the angle: phase, octant reduction, eight-term series
// depends on aapm_pkg; depth matches the axis divider
`default_nettype none

module aapm_sincos (
  input  logic              clk,
  input  logic              en,
  input  logic [31:0]       theta,
  output aapm_pkg::aapm_sc_t out_sc
);
  import aapm_pkg::*;

  localparam logic [29:0] TURN_SCALE  = 30'd683565276;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [63:0] HALF_LSB    = 64'd1 << 29;
  localparam int TERMS      = 7;
  localparam int CORE       = 19;
  localparam int PAD_STAGES = DIV_STEPS - CORE;

  // reciprocals ceil(2^sh / d) for the series denominators
  localparam logic [31:0] SIN_M [TERMS] = '{
    32'(((64'd1 << 34) + 64'd5)   / 64'd6),
    32'(((64'd1 << 36) + 64'd19)  / 64'd20),
    32'(((64'd1 << 37) + 64'd41)  / 64'd42),
    32'(((64'd1 << 38) + 64'd71)  / 64'd72),
    32'(((64'd1 << 38) + 64'd109) / 64'd110),
    32'(((64'd1 << 39) + 64'd155) / 64'd156),
    32'(((64'd1 << 39) + 64'd209) / 64'd210)
  };
  localparam logic [5:0] SIN_SH [TERMS] = '{
    6'd34, 6'd36, 6'd37, 6'd38, 6'd38, 6'd39, 6'd39
  };
  localparam logic [31:0] COS_M [TERMS] = '{
    32'(((64'd1 << 32) + 64'd1)   / 64'd2),
    32'(((64'd1 << 35) + 64'd11)  / 64'd12),
    32'(((64'd1 << 36) + 64'd29)  / 64'd30),
    32'(((64'd1 << 37) + 64'd55)  / 64'd56),
    32'(((64'd1 << 38) + 64'd89)  / 64'd90),
    32'(((64'd1 << 39) + 64'd131) / 64'd132),
    32'(((64'd1 << 39) + 64'd181) / 64'd182)
  };
  localparam logic [5:0] COS_SH [TERMS] = '{
    6'd32, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd39
  };

  logic [61:0] ph_prod;
  logic [31:0] ph_r;
  logic [29:0] mag2_r;
  logic        neg2_r, neg3_r, neg4_r;
  logic [1:0]  q2_r, q3_r, q4_r;
  logic [60:0] x_prod;
  logic [30:0] x3_r;
  logic [61:0] x2_prod;
  logic [30:0] x2_r, x4_r;

  // series sources and registers, multiply stage then divide stage per term
  logic [30:0]        a_ts [0:TERMS-1];
  logic [30:0]        a_tc [0:TERMS-1];
  logic signed [33:0] a_s  [0:TERMS-1];
  logic signed [33:0] a_c  [0:TERMS-1];
  logic [30:0]        a_x2 [0:TERMS-1];
  logic               a_ng [0:TERMS-1];
  logic [1:0]         a_q  [0:TERMS-1];

  logic [31:0]        ns_r  [0:TERMS-1];
  logic [31:0]        nc_r  [0:TERMS-1];
  logic signed [33:0] sa_r  [0:TERMS-1];
  logic signed [33:0] ca_r  [0:TERMS-1];
  logic [30:0]        x2a_r [0:TERMS-1];
  logic               nga_r [0:TERMS-1];
  logic [1:0]         qa_r  [0:TERMS-1];

  logic [30:0]        ts_r  [0:TERMS-1];
  logic [30:0]        tc_r  [0:TERMS-1];
  logic signed [33:0] sb_r  [0:TERMS-1];
  logic signed [33:0] cb_r  [0:TERMS-1];
  logic [30:0]        x2b_r [0:TERMS-1];
  logic               ngb_r [0:TERMS-1];
  logic [1:0]         qb_r  [0:TERMS-1];

  logic signed [33:0] sf_r, cf_r;
  logic               ngf_r;
  logic [1:0]         qf_r;
  logic signed [33:0] sv;
  aapm_sc_t           sc_nxt;
  aapm_sc_t           pad_r [0:PAD_STAGES-1];

  assign ph_prod = 62'(theta) * 62'(TURN_SCALE);
  assign x_prod  = 61'(mag2_r) * 61'(HALF_PI_Q30) + 61'(HALF_LSB);
  assign x2_prod = 62'(x3_r) * 62'(x3_r) + 62'(HALF_LSB);

  always_comb begin
    a_ts[0] = x4_r;
    a_tc[0] = ONE_Q30[30:0];
    a_s[0]  = '0;
    a_c[0]  = '0;
    a_x2[0] = x2_r;
    a_ng[0] = neg4_r;
    a_q[0]  = q4_r;
    for (int k = 1; k < TERMS; k++) begin
      a_ts[k] = ts_r[k-1];
      a_tc[k] = tc_r[k-1];
      a_s[k]  = sb_r[k-1];
      a_c[k]  = cb_r[k-1];
      a_x2[k] = x2b_r[k-1];
      a_ng[k] = ngb_r[k-1];
      a_q[k]  = qb_r[k-1];
    end
  end

  // sign of the reduced angle, then quadrant swap
  always_comb begin
    sv = ngf_r ? -sf_r : sf_r;
    case (qf_r)
      2'd0:    begin sc_nxt.s = 32'(sv);    sc_nxt.c = 32'(cf_r);  end
      2'd1:    begin sc_nxt.s = 32'(cf_r);  sc_nxt.c = 32'(-sv);   end
      2'd2:    begin sc_nxt.s = 32'(-sv);   sc_nxt.c = 32'(-cf_r); end
      default: begin sc_nxt.s = 32'(-cf_r); sc_nxt.c = 32'(sv);    end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // phase in turns
      ph_r <= ph_prod[59:28];

      // fold into [-1/8, 1/8) turn
      if (ph_r[29]) begin
        mag2_r <= 30'({1'b1, 30'd0} - {1'b0, ph_r[29:0]});
        neg2_r <= 1'b1;
        q2_r   <= ph_r[31:30] + 2'd1;
      end else begin
        mag2_r <= ph_r[29:0];
        neg2_r <= 1'b0;
        q2_r   <= ph_r[31:30];
      end

      // to radians
      x3_r   <= 31'(x_prod >> 30);
      neg3_r <= neg2_r;
      q3_r   <= q2_r;

      // square
      x2_r   <= 31'(x2_prod >> 30);
      x4_r   <= x3_r;
      neg4_r <= neg3_r;
      q4_r   <= q3_r;

      for (int k = 0; k < TERMS; k++) begin
        // accumulate the previous term and form the next product
        ns_r[k]  <= 32'((63'(a_ts[k]) * 63'(a_x2[k]) + 63'(HALF_LSB)) >> 30);
        nc_r[k]  <= 32'((63'(a_tc[k]) * 63'(a_x2[k]) + 63'(HALF_LSB)) >> 30);
        sa_r[k]  <= (k % 2 == 1) ? a_s[k] - $signed({3'b0, a_ts[k]})
                                 : a_s[k] + $signed({3'b0, a_ts[k]});
        ca_r[k]  <= (k % 2 == 1) ? a_c[k] - $signed({3'b0, a_tc[k]})
                                 : a_c[k] + $signed({3'b0, a_tc[k]});
        x2a_r[k] <= a_x2[k];
        nga_r[k] <= a_ng[k];
        qa_r[k]  <= a_q[k];

        // divide by the series denominator
        ts_r[k]  <= 31'((64'(ns_r[k]) * 64'(SIN_M[k])) >> SIN_SH[k]);
        tc_r[k]  <= 31'((64'(nc_r[k]) * 64'(COS_M[k])) >> COS_SH[k]);
        sb_r[k]  <= sa_r[k];
        cb_r[k]  <= ca_r[k];
        x2b_r[k] <= x2a_r[k];
        ngb_r[k] <= nga_r[k];
        qb_r[k]  <= qa_r[k];
      end

      // last term is subtracted
      sf_r  <= sb_r[TERMS-1] - $signed({3'b0, ts_r[TERMS-1]});
      cf_r  <= cb_r[TERMS-1] - $signed({3'b0, tc_r[TERMS-1]});
      ngf_r <= ngb_r[TERMS-1];
      qf_r  <= qb_r[TERMS-1];

      // quadrant result and alignment delay
      pad_r[0] <= sc_nxt;
      for (int p = 1; p < PAD_STAGES; p++) pad_r[p] <= pad_r[p-1];
    end
  end

  assign out_sc = pad_r[PAD_STAGES-1];

endmodule

`default_nettype wire

// File: hdl/aapm_rot.sv
// rotation assembly: axis clamp, Q2.30 products, Rodrigues sum and saturation
// depends on aapm_pkg
`default_nettype none

module aapm_rot (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  aapm_pkg::aapm_axis_t in_axis,
  input  aapm_pkg::aapm_sc_t   in_sc,
  output logic                 out_valid,
  output aapm_pkg::aapm_out_t  out_data
);
  import aapm_pkg::*;

  localparam logic [63:0]        HALF_LSB = 64'd1 << 29;
  localparam logic signed [35:0] POS_ONE  = 36'sd1073741824;
  localparam logic signed [35:0] NEG_ONE  = -36'sd1073741824;
  localparam logic signed [33:0] ONE34    = 34'sd1073741824;

  // Q.30 product, rounded half away from zero
  function automatic logic signed [33:0] qmul(input logic signed [33:0] a,
                                              input logic signed [33:0] b);
    logic [33:0] ua;
    logic [33:0] ub;
    logic [63:0] p;
    logic [33:0] r;
    ua = a[33] ? 34'(-a) : 34'(a);
    ub = b[33] ? 34'(-b) : 34'(b);
    p  = 64'(ua[31:0]) * 64'(ub[31:0]) + HALF_LSB;
    r  = 34'(p >> 30);
    qmul = (a[33] ^ b[33]) ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [35:0] v);
    if (v > POS_ONE) sat = 32'(POS_ONE);
    else if (v < NEG_ONE) sat = 32'(NEG_ONE);
    else sat = 32'(v);
  endfunction

  logic [4:0]         vld_r;
  logic               tiny_r [0:3];
  aapm_side_t         side_r [0:3];

  logic signed [33:0] a_r [3];
  logic signed [33:0] s1_r, omc1_r;
  logic signed [33:0] p00_r, p11_r, p22_r, p01_r, p02_r, p12_r;
  logic signed [33:0] sa2_r [3];
  logic signed [33:0] omc2_r;
  logic signed [33:0] k00_r, k11_r, k22_r, k01_r, k02_r, k12_r;
  logic signed [33:0] sa3_r [3];
  logic signed [33:0] omc3_r;
  logic signed [33:0] w00_r, w11_r, w22_r, w01_r, w02_r, w12_r;
  logic signed [33:0] sa4_r [3];
  logic [30:0]        qc [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (in_axis.q[i] > ONE_Q30[30:0]) ? ONE_Q30[30:0] : in_axis.q[i];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // signed axis and one minus cosine
      for (int i = 0; i < 3; i++) begin
        a_r[i] <= in_axis.side.neg[i] ? -$signed({3'b0, qc[i]}) : $signed({3'b0, qc[i]});
      end
      s1_r      <= 34'(in_sc.s);
      omc1_r    <= ONE34 - 34'(in_sc.c);
      tiny_r[0] <= in_axis.tiny;
      side_r[0] <= in_axis.side;

      // axis products and sine-scaled axis
      p00_r <= qmul(a_r[0], a_r[0]);
      p11_r <= qmul(a_r[1], a_r[1]);
      p22_r <= qmul(a_r[2], a_r[2]);
      p01_r <= qmul(a_r[0], a_r[1]);
      p02_r <= qmul(a_r[0], a_r[2]);
      p12_r <= qmul(a_r[1], a_r[2]);
      for (int i = 0; i < 3; i++) sa2_r[i] <= qmul(s1_r, a_r[i]);
      omc2_r    <= omc1_r;
      tiny_r[1] <= tiny_r[0];
      side_r[1] <= side_r[0];

      // K squared
      k00_r <= -(p11_r + p22_r);
      k11_r <= -(p00_r + p22_r);
      k22_r <= -(p00_r + p11_r);
      k01_r <= p01_r;
      k02_r <= p02_r;
      k12_r <= p12_r;
      sa3_r     <= sa2_r;
      omc3_r    <= omc2_r;
      tiny_r[2] <= tiny_r[1];
      side_r[2] <= side_r[1];

      // scale by one minus cosine
      w00_r <= qmul(omc3_r, k00_r);
      w11_r <= qmul(omc3_r, k11_r);
      w22_r <= qmul(omc3_r, k22_r);
      w01_r <= qmul(omc3_r, k01_r);
      w02_r <= qmul(omc3_r, k02_r);
      w12_r <= qmul(omc3_r, k12_r);
      sa4_r     <= sa3_r;
      tiny_r[3] <= tiny_r[2];
      side_r[3] <= side_r[2];

      // identity plus the two terms, saturated; tiny angle gives identity
      if (tiny_r[3]) begin
        out_data.m00 <= $signed(ONE_Q30);
        out_data.m01 <= '0;
        out_data.m02 <= '0;
        out_data.m10 <= '0;
        out_data.m11 <= $signed(ONE_Q30);
        out_data.m12 <= '0;
        out_data.m20 <= '0;
        out_data.m21 <= '0;
        out_data.m22 <= $signed(ONE_Q30);
      end else begin
        out_data.m00 <= sat(36'(ONE34) + 36'(w00_r));
        out_data.m01 <= sat(36'(w01_r) - 36'(sa4_r[2]));
        out_data.m02 <= sat(36'(w02_r) + 36'(sa4_r[1]));
        out_data.m10 <= sat(36'(w01_r) + 36'(sa4_r[2]));
        out_data.m11 <= sat(36'(ONE34) + 36'(w11_r));
        out_data.m12 <= sat(36'(w12_r) - 36'(sa4_r[0]));
        out_data.m20 <= sat(36'(w02_r) - 36'(sa4_r[1]));
        out_data.m21 <= sat(36'(w12_r) + 36'(sa4_r[0]));
        out_data.m22 <= sat(36'(ONE34) + 36'(w22_r));
      end
      out_data.out_tx <= side_r[3].tx;
      out_data.out_ty <= side_r[3].ty;
      out_data.out_tz <= side_r[3].tz;
    end
  end

  assign out_valid = vld_r[4];

endmodule

`default_nettype wire

// File: hdl/axis_angle_to_pose_matrix_unit.sv
// axis-angle pose to rotation matrix and translation, fully pipelined
// the square root takes two radicand bits per stage, the axis divider makes one quotient
// bit per stage (sin/cos runs beside it), then comes the assembly
// throughput one pose per cycle; the whole pipe holds while a result is stalled
// reset (synchronous, active low) clears every valid bit, payload is not reset
// depends on aapm_pkg, aapm_sqrt, aapm_div, aapm_sincos, aapm_rot
`default_nettype none

module axis_angle_to_pose_matrix_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  aapm_pkg::aapm_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output aapm_pkg::aapm_out_t out_data
);
  import aapm_pkg::*;

  logic       en;
  logic       root_valid;
  aapm_root_t root;
  logic       axis_valid;
  aapm_axis_t axis;
  aapm_sc_t   sc;

  // pipe advances unless a finished result is held
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  aapm_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (root_valid),
    .out_root  (root)
  );

  aapm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (root_valid),
    .in_root   (root),
    .out_valid (axis_valid),
    .out_axis  (axis)
  );

  aapm_sincos u_sincos (
    .clk    (clk),
    .en     (en),
    .theta  (root.theta),
    .out_sc (sc)
  );

  aapm_rot u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (axis_valid),
    .in_axis   (axis),
    .in_sc     (sc),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // no result straight out of reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // diagonal stays in the saturated range (lower bound checked on m00 only)
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_data.m00) <= $signed(ONE_Q30)) &&
                  ($signed(out_data.m00) >= -$signed(ONE_Q30)) &&
                  ($signed(out_data.m11) <= $signed(ONE_Q30)) &&
                  ($signed(out_data.m22) <= $signed(ONE_Q30)))
    else $error("diagonal out of range");

  // a held result keeps the pipe frozen
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(axis_valid)))
    else $error("pipe moved under a stalled result");

endmodule

`default_nettype wire
